// ===== hdl/bcd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcd_pkg: shared types and constants for the BC1/BC2/BC3 block decoder
// Holds the format codes, register map and the palette entry handed from the
// front end, through the queue, to the texel back end.
// ----------------------------------------------------------------------------
package bcd_pkg;

  // Format codes (format_mode register); the unused code decodes as BC1
  localparam logic [1:0] MODE_BC1  = 2'd0;
  localparam logic [1:0] MODE_BC2  = 2'd1;
  localparam logic [1:0] MODE_BC3  = 2'd2;
  localparam logic [1:0] MODE_RSVD = 2'd3;

  // Register map: APB word index
  localparam int unsigned PADDR_W        = 3;
  localparam logic        REG_FORMAT_MODE = 1'b0;

  // Beat widths
  localparam int unsigned S_TDATA_W = 128;
  localparam int unsigned M_TDATA_W = 40;

  // Decoded block, ready for texel selection
  typedef struct packed {
    logic [1:0]       mode;
    logic             three;     // BC1 three-colour mode, index 3 transparent
    logic [3:0][7:0]  red;
    logic [3:0][7:0]  green;
    logic [3:0][7:0]  blue;
    logic [7:0][7:0]  apal;      // BC3 alpha palette
    logic [31:0]      cidx;
    logic [63:0]      aw;
  } pal_entry_t;

endpackage

// ===== hdl/bcd_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcd_front: block intake and palette build
// Stage one latches a block with its weighted endpoint sums; stage two divides
// the sums by constant reciprocals and pushes a palette entry to the queue.
// ----------------------------------------------------------------------------
module bcd_front import bcd_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [1:0]           mode,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [S_TDATA_W-1:0] s_tdata,
  output logic                 q_push,
  output pal_entry_t           q_entry,
  input  logic                 q_full
);

  // x/3 for x <= 765
  function automatic logic [7:0] div3(input logic [9:0] x);
    logic [20:0] p;
    p = {11'd0, x} * 21'd683;
    return p[18:11];
  endfunction

  // x/7 for x <= 1785
  function automatic logic [7:0] div7(input logic [10:0] x);
    logic [22:0] p;
    p = {12'd0, x} * 23'd2341;
    return p[21:14];
  endfunction

  // x/5 for x <= 1275
  function automatic logic [7:0] div5(input logic [10:0] x);
    logic [22:0] p;
    p = {12'd0, x} * 23'd3277;
    return p[21:14];
  endfunction

  // Input fields
  logic [63:0] in_aw;
  logic [15:0] in_c0, in_c1;
  logic [31:0] in_cidx;

  assign in_aw   = s_tdata[63:0];
  assign in_c0   = s_tdata[79:64];
  assign in_c1   = s_tdata[95:80];
  assign in_cidx = s_tdata[127:96];

  // Stage one combinational: widen endpoints, weighted sums
  logic [1:0][7:0]   ep_r, ep_g, ep_b;
  logic [2:0][9:0]   sum2_next, sum3_next;
  logic [7:2][10:0]  asum_next;
  logic              four_next, gt_next;
  logic [7:0]        a0_in, a1_in;
  logic [2:0]        wa, wb;
  logic [2:0][7:0]   e0, e1;

  assign a0_in = in_aw[7:0];
  assign a1_in = in_aw[15:8];

  always_comb begin
    ep_r[0] = {in_c0[15:11], in_c0[15:13]};
    ep_g[0] = {in_c0[10:5],  in_c0[10:9]};
    ep_b[0] = {in_c0[4:0],   in_c0[4:2]};
    ep_r[1] = {in_c1[15:11], in_c1[15:13]};
    ep_g[1] = {in_c1[10:5],  in_c1[10:9]};
    ep_b[1] = {in_c1[4:0],   in_c1[4:2]};
    four_next = (mode == MODE_BC2) || (mode == MODE_BC3) || (in_c0 > in_c1);
    gt_next   = a0_in > a1_in;
    e0 = {ep_b[0], ep_g[0], ep_r[0]};
    e1 = {ep_b[1], ep_g[1], ep_r[1]};
    // colour sums: thirds in four-colour mode, half and black otherwise
    for (int ch = 0; ch < 3; ch++) begin
      if (four_next) begin
        sum2_next[ch] = {1'b0, e0[ch], 1'b0} + {2'b0, e1[ch]};
        sum3_next[ch] = {2'b0, e0[ch]} + {1'b0, e1[ch], 1'b0};
      end else begin
        sum2_next[ch] = {2'b0, e0[ch]} + {2'b0, e1[ch]};
        sum3_next[ch] = '0;
      end
    end
    // alpha sums; codes six and seven are fixed later when a0 <= a1
    for (int c = 2; c < 8; c++) begin
      wa = gt_next ? 3'(8 - c) : 3'(6 - c);
      wb = 3'(c - 1);
      asum_next[c] = ({3'd0, a0_in} * {8'd0, wa}) + ({3'd0, a1_in} * {8'd0, wb});
    end
  end

  // Stage one registers
  logic              s1_valid;
  logic [1:0][7:0]   s1_r, s1_g, s1_b;
  logic [2:0][9:0]   s1_sum2, s1_sum3;
  logic [7:2][10:0]  s1_asum;
  logic              s1_four, s1_gt;
  logic [1:0]        s1_mode;
  logic [31:0]       s1_cidx;
  logic [63:0]       s1_aw;

  assign s_tready = !s1_valid || !q_full;
  assign q_push   = s1_valid && !q_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_tready) begin
      s1_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      s1_r    <= ep_r;
      s1_g    <= ep_g;
      s1_b    <= ep_b;
      s1_sum2 <= sum2_next;
      s1_sum3 <= sum3_next;
      s1_asum <= asum_next;
      s1_four <= four_next;
      s1_gt   <= gt_next;
      s1_mode <= mode;
      s1_cidx <= in_cidx;
      s1_aw   <= in_aw;
    end
  end

  // Stage two: constant divides, entry assembly
  logic [2:0][7:0] p2, p3;

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      p2[ch] = s1_four ? div3(s1_sum2[ch]) : s1_sum2[ch][8:1];
      p3[ch] = s1_four ? div3(s1_sum3[ch]) : 8'd0;
    end
    q_entry.mode  = s1_mode;
    q_entry.three = !s1_four;
    q_entry.red   = {p3[0], p2[0], s1_r[1], s1_r[0]};
    q_entry.green = {p3[1], p2[1], s1_g[1], s1_g[0]};
    q_entry.blue  = {p3[2], p2[2], s1_b[1], s1_b[0]};
    q_entry.cidx  = s1_cidx;
    q_entry.aw    = s1_aw;
    q_entry.apal[0] = s1_aw[7:0];
    q_entry.apal[1] = s1_aw[15:8];
    for (int c = 2; c < 8; c++) begin
      if (s1_gt)      q_entry.apal[c] = div7(s1_asum[c]);
      else if (c < 6) q_entry.apal[c] = div5(s1_asum[c]);
      else if (c == 6) q_entry.apal[c] = 8'd0;
      else            q_entry.apal[c] = 8'd255;
    end
  end

endmodule

// ===== hdl/bcd_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcd_queue: palette entry queue
// Small register FIFO between the front end and the texel back end.
// ----------------------------------------------------------------------------
module bcd_queue import bcd_pkg::*; #(
  parameter int unsigned DEPTH = 2
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  pal_entry_t wr_entry,
  output logic       full,
  output logic       valid,
  output pal_entry_t head,
  input  logic       pop
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  pal_entry_t       store [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;

  assign full  = (count == CNT_W'(DEPTH));
  assign valid = (count != '0);
  assign head  = store[rd_ptr];

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      store[wr_ptr] <= wr_entry;
    end
  end

endmodule

// ===== hdl/bcd_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcd_back: texel emitter
// Walks the sixteen texels of the head entry, one per beat, into the output
// register, and releases the entry with the last texel.
// ----------------------------------------------------------------------------
module bcd_back import bcd_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 q_valid,
  input  pal_entry_t           q_head,
  output logic                 q_pop,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [M_TDATA_W-1:0] m_tdata,
  output logic                 m_tlast
);

  logic [3:0] k;
  logic       adv;
  logic [1:0] ci;
  logic [3:0] nib;
  logic [5:0] code_off;
  logic [2:0] code;
  logic [7:0] alpha_sel;

  assign adv   = !m_tvalid || m_tready;
  assign q_pop = adv && q_valid && (k == 4'd15);

  // Per-texel selection
  always_comb begin
    ci       = q_head.cidx[{k, 1'b0} +: 2];
    nib      = q_head.aw[{k, 2'b00} +: 4];
    code_off = 6'd16 + {2'b00, k} + {1'b0, k, 1'b0};
    code     = q_head.aw[code_off +: 3];
    unique case (q_head.mode)
      MODE_BC2: alpha_sel = {nib, nib};
      MODE_BC3: alpha_sel = q_head.apal[code];
      default:  alpha_sel = (q_head.three && (ci == 2'd3)) ? 8'd0 : 8'd255;
    endcase
  end

  // Texel counter and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      k        <= '0;
      m_tvalid <= 1'b0;
    end else if (adv) begin
      m_tvalid <= q_valid;
      if (q_valid) k <= k + 1'b1;
    end
  end

  // Output beat
  always_ff @(posedge clk) begin
    if (adv && q_valid) begin
      m_tdata <= {4'd0, alpha_sel, q_head.blue[ci], q_head.green[ci],
                  q_head.red[ci], k};
      m_tlast <= (k == 4'd15);
    end
  end

endmodule

// ===== hdl/bc1_bc2_bc3_block_decoder_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bc1_bc2_bc3_block_decoder_top: BC1/BC2/BC3 4x4 block decoder
// Takes one compressed block per input beat and emits its sixteen RGBA
// texels in row-major order.
// ----------------------------------------------------------------------------
//  Channel   Dir  Handshake          Beat
//  s_*       in   tvalid/tready      one compressed block
//  m_*       out  tvalid/tready      one decoded texel, tlast on texel 15
//  APB       in   psel/penable       format_mode at byte address 0
//
//  Block rate is set by the back end emitting one texel a cycle when the
//  output is not stalled. The first texel passes the front register, the
//  queue entry and the output register before it is valid on the output.
//  The front end keeps taking blocks while the back end drains, until the
//  entry queue and the front stage are full; output stalls hold the texel.
//  Synchronous reset clears the pipeline valids, queue and format_mode.
// ----------------------------------------------------------------------------
module bc1_bc2_bc3_block_decoder_top import bcd_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic                 clk,
  input  logic                 rst,
  // block input: alpha_word[63:0], color0[79:64], color1[95:80],
  // color_indices[127:96]
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [S_TDATA_W-1:0] s_tdata,
  // texel output: texel_index[3:0], red[11:4], green[19:12], blue[27:20],
  // alpha[35:28], zero pad[39:36]
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [M_TDATA_W-1:0] m_tdata,
  output logic                 m_tlast,
  // configuration
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [PADDR_W-1:0]   paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  logic [1:0] format_mode;

  // Register access
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_FORMAT_MODE) ? {30'd0, format_mode} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      format_mode <= MODE_BC1;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_FORMAT_MODE)) begin
      format_mode <= pwdata[1:0];
    end
  end

  // Front end, queue, back end
  logic       q_push, q_full, q_valid, q_pop;
  pal_entry_t q_wr, q_head;

  bcd_front u_front (
    .clk      (clk),
    .rst      (rst),
    .mode     (format_mode),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .q_push   (q_push),
    .q_entry  (q_wr),
    .q_full   (q_full)
  );

  bcd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .wr_entry (q_wr),
    .full     (q_full),
    .valid    (q_valid),
    .head     (q_head),
    .pop      (q_pop)
  );

  bcd_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_head   (q_head),
    .q_pop    (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  // Checks
  a_last_on_fifteen: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tlast == (m_tdata[3:0] == 4'd15)))
    else $error("tlast does not match texel index");

  a_index_steps: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready) |=> (!m_tvalid || (m_tdata[3:0] == $past(m_tdata[3:0]) + 4'd1)))
    else $error("texel index skipped or repeated");

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_full)
    else $error("push into full queue");

  a_pop_valid: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_valid)
    else $error("pop from empty queue");

endmodule
